### src/egd_pkg.sv
// Shared types and constants of the Exp-Golomb ue(v) decoder.
`default_nettype none

package egd_pkg;

    // Field widths
    localparam int unsigned ByteW  = 8;
    localparam int unsigned ValueW = 32;
    localparam int unsigned RunW   = 6;
    localparam int unsigned PosW   = 3;

    // Longest zero run accepted as a prefix
    localparam logic [RunW-1:0] MaxPrefix = RunW'(31);

    // Default depth of the request queue between front and back
    localparam int unsigned QueueDepthDefault = 2;

    // One input request
    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             restart;
    } t_req;

    // One decoded result
    typedef struct packed {
        logic [ValueW-1:0] code_value;
        logic              prefix_error;
        logic              last_of_run;
    } t_res;

    // Handshake between queue head and bit engine
    typedef struct packed {
        logic valid;
        t_req req;
    } t_head;

endpackage

`default_nettype wire

### src/egd_byte_if.sv
// Request channel: one bitstream byte with its restart flag.
`default_nettype none

interface egd_byte_if
    import egd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] data_byte;
    logic             restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

`default_nettype wire

### src/egd_result_if.sv
// Result channel: one decoded ue(v) value per transfer; a request may give none or several.
`default_nettype none

interface egd_result_if
    import egd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ValueW-1:0] code_value;
    logic              prefix_error;
    logic              last_of_run;

    modport source (output valid, output code_value, output prefix_error,
                    output last_of_run, input ready);
    modport sink   (input valid, input code_value, input prefix_error,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

### src/exp_golomb_ue_decoder_unit.sv
// Top level of the unsigned Exp-Golomb ue(v) bitstream decoder.
//
// Requests arrive on i_req, one bitstream byte each, read from bit 7 down.
// restart set on a request drops any partly read code before that byte.
// Each completed code leaves on o_res as 2^n - 1 + suffix; a zero run longer
// than the maximum prefix gives one result with prefix_error set and value 0,
// and decoding starts afresh. last_of_run marks the final result of a byte;
// a byte that completes no code gives no result.
// Throughput: the bit engine walks one bit a cycle unless it stalls, so it
// takes a new byte only once all bits of the last are read; up to eight results
// per byte leave at one per cycle while the receiver is ready. Each result is
// held until later bits of the byte show whether it is the byte's last.
// The request queue takes new bytes while the engine works and while the
// output register waits; a stalled receiver holds results in place and the
// engine pauses only on a bit that completes another code.
// Reset is synchronous and active low: queue empty, no result pending.
`default_nettype none

module exp_golomb_ue_decoder_unit
    import egd_pkg::*;
#(
    parameter int unsigned QueueDepth = QueueDepthDefault
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    egd_byte_if.sink     i_req,
    egd_result_if.source o_res
);
    t_head head;
    logic  pop;

    // Front: request queue
    egd_in_queue #(
        .Depth (QueueDepth)
    ) u_in_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_head  (head),
        .i_pop   (pop)
    );

    // Back: bit-serial decoder
    egd_bit_engine u_bit_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

### src/egd_in_queue.sv
// Front end: accepts byte requests into a short queue ahead of the bit engine.
`default_nettype none

module egd_in_queue
    import egd_pkg::*;
#(
    parameter int unsigned Depth = QueueDepthDefault
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    egd_byte_if.sink   i_req,
    output t_head      o_head,
    input  wire        i_pop
);
    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    t_req            r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;

    logic push;
    logic pop;

    // Handshake
    assign i_req.ready = (r_count != FullCnt);
    assign push        = i_req.valid && i_req.ready;
    assign pop         = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.req   = r_mem[r_rd_ptr];

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + PtrW'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + PtrW'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CntW'(1);
        end else if (pop && !push) begin
            n_count = r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= '{data_byte: i_req.data_byte, restart: i_req.restart};
        end
    end

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FullCnt)
        else $error("queue fill count beyond depth");
    a_pop_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && r_count == '0) |=> (r_count == '0) || $past(push))
        else $error("queue popped while empty");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == FullCnt) |-> !push)
        else $error("request taken while queue full");

endmodule

`default_nettype wire

### src/egd_bit_engine.sv
// Back end: walks each queued byte one bit a cycle, pausing on stalls, and emits decoded results.
`default_nettype none

module egd_bit_engine
    import egd_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  t_head        i_head,
    output logic         o_pop,
    egd_result_if.source o_res
);
    // Code progress
    logic              r_rd_suffix, n_rd_suffix;
    logic [RunW-1:0]   r_zero_run,  n_zero_run;
    logic [RunW-1:0]   r_sfx_left,  n_sfx_left;
    logic [ValueW-1:0] r_accum,     n_accum;
    logic [PosW-1:0]   r_bit_pos;

    // Result held until the byte's last result is known
    logic              r_pend_valid;
    logic              r_pend_last;
    logic [ValueW-1:0] r_pend_value;
    logic              r_pend_err;

    // Output register
    logic              r_out_valid;
    t_res              r_out;

    logic              cur_rd_suffix;
    logic [RunW-1:0]   cur_zero_run;
    logic [RunW-1:0]   cur_sfx_left;
    logic [ValueW-1:0] cur_accum;
    logic              bit_in;
    logic              res_valid;
    logic [ValueW-1:0] res_value;
    logic              res_err;
    logic [RunW-1:0]   run_inc;
    logic [RunW-1:0]   left_dec;
    logic [ValueW-1:0] accum_sh;
    logic              out_free;
    logic              stall;
    logic              step;
    logic              final_bit;
    logic              push_pend;

    // Restart drops partial code ahead of the byte's first bit
    always_comb begin
        if (i_head.req.restart && (r_bit_pos == PosW'(ByteW - 1))) begin
            cur_rd_suffix = 1'b0;
            cur_zero_run  = '0;
            cur_sfx_left  = '0;
            cur_accum     = '0;
        end else begin
            cur_rd_suffix = r_rd_suffix;
            cur_zero_run  = r_zero_run;
            cur_sfx_left  = r_sfx_left;
            cur_accum     = r_accum;
        end
    end

    assign bit_in   = i_head.req.data_byte[r_bit_pos];
    assign run_inc  = cur_zero_run + RunW'(1);
    assign left_dec = cur_sfx_left - RunW'(1);
    assign accum_sh = {cur_accum[ValueW-2:0], bit_in};

    // One decoding step on the current bit
    always_comb begin
        n_rd_suffix = cur_rd_suffix;
        n_zero_run  = cur_zero_run;
        n_sfx_left  = cur_sfx_left;
        n_accum     = cur_accum;
        res_valid   = 1'b0;
        res_value   = '0;
        res_err     = 1'b0;
        if (!cur_rd_suffix) begin
            if (!bit_in) begin
                if (run_inc > MaxPrefix) begin
                    res_valid  = 1'b1;
                    res_err    = 1'b1;
                    n_zero_run = '0;
                end else begin
                    n_zero_run = run_inc;
                end
            end else if (cur_zero_run == '0) begin
                res_valid = 1'b1;
            end else begin
                n_rd_suffix = 1'b1;
                n_sfx_left  = cur_zero_run;
                n_accum     = '0;
            end
        end else begin
            if (left_dec == '0) begin
                res_valid   = 1'b1;
                res_value   = ((ValueW'(1) << cur_zero_run) - ValueW'(1)) + accum_sh;
                n_rd_suffix = 1'b0;
                n_zero_run  = '0;
                n_sfx_left  = '0;
                n_accum     = '0;
            end else begin
                n_sfx_left = left_dec;
                n_accum    = accum_sh;
            end
        end
    end

    // Flow control: a new result pushes the held one out
    assign out_free  = !r_out_valid || o_res.ready;
    assign stall     = res_valid && r_pend_valid && !out_free;
    assign step      = i_head.valid && !stall;
    assign final_bit = (r_bit_pos == '0);
    assign o_pop     = step && final_bit;
    assign push_pend = r_pend_valid && out_free && (r_pend_last || (step && res_valid));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_suffix  <= 1'b0;
            r_zero_run   <= '0;
            r_sfx_left   <= '0;
            r_accum      <= '0;
            r_bit_pos    <= PosW'(ByteW - 1);
            r_pend_valid <= 1'b0;
            r_pend_last  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // Code state and bit position
            if (step) begin
                r_rd_suffix <= n_rd_suffix;
                r_zero_run  <= n_zero_run;
                r_sfx_left  <= n_sfx_left;
                r_accum     <= n_accum;
                r_bit_pos   <= r_bit_pos - PosW'(1);
            end
            // Held result
            if (step && res_valid) begin
                r_pend_valid <= 1'b1;
                r_pend_last  <= final_bit;
            end else if (push_pend) begin
                r_pend_valid <= 1'b0;
            end else if (step && final_bit && r_pend_valid) begin
                r_pend_last <= 1'b1;
            end
            // Output register
            if (push_pend) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers; a held result marked last belongs to a finished byte
    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_pend_value <= res_value;
            r_pend_err   <= res_err;
        end
        if (push_pend) begin
            r_out.code_value   <= r_pend_value;
            r_out.prefix_error <= r_pend_err;
            r_out.last_of_run  <= r_pend_last;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.code_value   = r_out.code_value;
    assign o_res.prefix_error = r_out.prefix_error;
    assign o_res.last_of_run  = r_out.last_of_run;

    // Checks
    a_suffix_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_suffix == (r_sfx_left != '0))
        else $error("suffix count out of step with suffix mode");
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_zero_run <= MaxPrefix)
        else $error("zero run beyond maximum prefix");
    a_last_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_valid && r_pend_last && !push_pend) |=> (r_pend_valid && r_pend_last))
        else $error("final result of a byte lost before output");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.prefix_error) |-> (r_out.code_value == '0))
        else $error("error result carries a value");

endmodule

`default_nettype wire
